### hdl/mbt_pkg.sv
// Package: shared constants, types and arithmetic helpers of the MLP trainer.
package mbt_pkg;

  localparam int INPUT_COUNT  = 9;
  localparam int HIDDEN_COUNT = 40;
  localparam int WEIGHT_WIDTH = 24;

  localparam int FIRST_COUNT  = INPUT_COUNT * HIDDEN_COUNT;
  localparam int WEIGHT_TOTAL = FIRST_COUNT + HIDDEN_COUNT;
  localparam int HID_W        = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int INP_W        = $clog2(INPUT_COUNT);
  localparam int FA_W         = $clog2(FIRST_COUNT);

  localparam int CMD_W        = 2;
  localparam int WIDX_W       = 9;
  localparam int WVAL_W       = 24;
  localparam int CELLS_W      = 18;
  localparam int TGT_W        = 4;
  localparam int ACT_W        = 17;
  localparam int MOVE_W       = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam int MUL_A_W      = 34;
  localparam int MUL_B_W      = 18;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;

  localparam int SIG_SIZE     = 256;
  localparam int SIG_IDX_W    = 8;
  localparam int SIG_IDX_LSB  = 12;
  localparam logic signed [PROD_W-1:0] SIG_HI = PROD_W'(524288);
  localparam logic signed [PROD_W-1:0] SIG_LO = -SIG_HI;
  localparam logic [63:0] EXP_STEP = 64'd4162825044;

  localparam logic [ACT_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [ACT_W-1:0] HALF_Q16 = 17'h08000;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 16'd6554;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_INFER = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOMENTUM   = 1'b0,
    CFG_LEARN_RATE = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOAD,
    ST_H_RD, ST_H_MUL, ST_H_ACC, ST_H_SIG,
    ST_O_RD, ST_O_MUL, ST_O_ACC, ST_O_SIG,
    ST_E_SQ, ST_E_DY, ST_E_DYR, ST_E_YD, ST_E_YDR,
    ST_U2_RD, ST_U2_M1, ST_U2_M2, ST_U2_M3, ST_U2_WR,
    ST_B_RD, ST_B_M1, ST_B_M2, ST_B_DH, ST_B_M3, ST_B_WR,
    ST_F_RD, ST_F_M1, ST_F_M2, ST_F_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e           step;
    logic             take;
    logic [HID_W-1:0] hid;
    logic [INP_W-1:0] inp;
    logic [FA_W-1:0]  addr;
  } mbt_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic out_busy;
  } mbt_status_t;

  // Add half an LSB, then arithmetic shift right (floor).
  function automatic logic signed [PROD_W-1:0] round_sh(input logic signed [PROD_W-1:0] v,
                                                        input int s);
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[s-1] = 1'b1;
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = '0;
    hi[WEIGHT_WIDTH-2:0] = '1;
    lo = ~hi;
    if (v > hi) return hi[WEIGHT_WIDTH-1:0];
    if (v < lo) return lo[WEIGHT_WIDTH-1:0];
    return v[WEIGHT_WIDTH-1:0];
  endfunction

  // Power chain of exp(-1/32) in Q0.32, evaluated at elaboration.
  function automatic logic [63:0] exp_pow(input int n);
    logic [63:0] p;
    p = 64'h1_0000_0000;
    for (int k = 1; k <= n; k++) begin
      p = (p * EXP_STEP + 64'h8000_0000) >> 32;
    end
    return p;
  endfunction

  // Desired output round(t * 65536 / 9); targets above nine saturate.
  function automatic logic [ACT_W-1:0] desired_q16(input logic [TGT_W-1:0] t);
    logic [ACT_W-1:0] r;
    case (t)
      4'd0:    r = 17'd0;
      4'd1:    r = 17'd7282;
      4'd2:    r = 17'd14564;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd29127;
      4'd5:    r = 17'd36409;
      4'd6:    r = 17'd43691;
      4'd7:    r = 17'd50972;
      4'd8:    r = 17'd58254;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

### hdl/mbt_if.sv
// Interfaces: input and result channels of the MLP trainer.
interface mbt_in_if import mbt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [WVAL_W-1:0] weight_value;
  logic [CELLS_W-1:0]       board_cells;
  logic [TGT_W-1:0]         target_position;

  modport source (output valid, command, weight_index, weight_value, board_cells,
                  target_position, input ready);
  modport sink (input valid, command, weight_index, weight_value, board_cells,
                target_position, output ready);
endinterface

interface mbt_out_if import mbt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  output_value;
  logic [MOVE_W-1:0] move_position;
  logic [ACT_W-1:0]  squared_error;

  modport source (output valid, output_value, move_position, squared_error, input ready);
  modport sink (input valid, output_value, move_position, squared_error, output ready);
endinterface

### hdl/mlp_backprop_trainer.sv
// Top level: 9-40-1 sigmoid perceptron trainer (SGD with momentum).
// Steps: a load writes the indexed weight; a no-op does nothing. Infer runs the
//   first-layer MACs, one sigmoid per hidden unit and the output MACs; train adds the
//   error terms, the output weight updates, the hidden deltas and the first-layer
//   weight updates. One shared multiplier forms every product.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: a clearing pass over every first-layer address zeroes the momentum stores;
//   no item is taken until it ends. Weights are undefined until loaded.
module mlp_backprop_trainer import mbt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mbt_in_if.sink                in_i,
  mbt_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] momentum_q, learn_rate_q;
  mbt_cmd_t              cmd;
  mbt_status_t           status;

  // Config registers: hold until written; the user must write only while idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      momentum_q   <= CFG_RESET;
      learn_rate_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == CFG_MOMENTUM) begin
        momentum_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_LEARN_RATE) begin
        learn_rate_q <= cfg_data_i;
      end
    end
  end

  // Sequencer: walks forward pass, error terms, hidden deltas and both update passes.
  mbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (status),
    .cmd_o      (cmd)
  );

  // Datapath: memories, multiplier, accumulator, result register.
  mbt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (status),
    .command_i         (in_i.command),
    .weight_index_i    (in_i.weight_index),
    .weight_value_i    (in_i.weight_value),
    .board_cells_i     (in_i.board_cells),
    .target_position_i (in_i.target_position),
    .momentum_factor_i (momentum_q),
    .learning_rate_i   (learn_rate_q),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .output_value_o    (out_o.output_value),
    .move_position_o   (out_o.move_position),
    .squared_error_o   (out_o.squared_error)
  );

`ifndef ASSERT_OFF
  // One item at a time: drop ready right after a transfer in.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken twice in a row");

  // Rounded output times nine stays within the move range.
  a_move_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.move_position <= 4'd9)
    else $error("move position out of range");

  // Squared error never exceeds one.
  a_sq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.squared_error <= 17'd65536)
    else $error("squared error out of range");
`endif

endmodule

### hdl/mbt_ctrl.sv
// Controller: sequencer state machine with loop counters for the MLP trainer.
module mbt_ctrl import mbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mbt_status_t st_i,
  output mbt_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [HID_W-1:0] hid_q, hid_d;
  logic [INP_W-1:0] inp_q, inp_d;
  logic [FA_W-1:0]  addr_q, addr_d;
  logic             hid_last, inp_last;

  assign hid_last = (hid_q == HID_W'(HIDDEN_COUNT - 1));
  assign inp_last = (inp_q == INP_W'(INPUT_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      hid_q   <= '0;
      inp_q   <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      hid_q   <= hid_d;
      inp_q   <= inp_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    hid_d   = hid_q;
    inp_d   = inp_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_q == FA_W'(FIRST_COUNT - 1)) begin
          state_d = ST_IDLE;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + FA_W'(1);
        end
      end
      ST_IDLE: if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        hid_d  = '0;
        inp_d  = '0;
        addr_d = '0;
        unique case (st_i.cmd)
          CMD_LOAD:             state_d = ST_LOAD;
          CMD_TRAIN, CMD_INFER: state_d = ST_H_RD;
          CMD_NOP:              state_d = ST_DONE;
        endcase
      end
      ST_LOAD:  state_d = ST_DONE;
      ST_H_RD:  state_d = ST_H_MUL;
      ST_H_MUL: state_d = ST_H_ACC;
      ST_H_ACC: begin
        if (inp_last) begin
          state_d = ST_H_SIG;
        end else begin
          inp_d   = inp_q + INP_W'(1);
          addr_d  = addr_q + FA_W'(HIDDEN_COUNT);
          state_d = ST_H_RD;
        end
      end
      ST_H_SIG: begin
        inp_d = '0;
        if (hid_last) begin
          hid_d   = '0;
          state_d = ST_O_RD;
        end else begin
          hid_d   = hid_q + HID_W'(1);
          addr_d  = FA_W'(hid_q) + FA_W'(1);
          state_d = ST_H_RD;
        end
      end
      ST_O_RD:  state_d = ST_O_MUL;
      ST_O_MUL: state_d = ST_O_ACC;
      ST_O_ACC: begin
        if (hid_last) begin
          state_d = ST_O_SIG;
        end else begin
          hid_d   = hid_q + HID_W'(1);
          state_d = ST_O_RD;
        end
      end
      ST_O_SIG: state_d = (st_i.cmd == CMD_TRAIN) ? ST_E_SQ : ST_DONE;
      ST_E_SQ:  state_d = ST_E_DY;
      ST_E_DY:  state_d = ST_E_DYR;
      ST_E_DYR: state_d = ST_E_YD;
      ST_E_YD:  state_d = ST_E_YDR;
      ST_E_YDR: begin
        hid_d   = '0;
        state_d = ST_U2_RD;
      end
      ST_U2_RD: state_d = ST_U2_M1;
      ST_U2_M1: state_d = ST_U2_M2;
      ST_U2_M2: state_d = ST_U2_M3;
      ST_U2_M3: state_d = ST_U2_WR;
      ST_U2_WR: begin
        if (hid_last) begin
          hid_d   = '0;
          state_d = ST_B_RD;
        end else begin
          hid_d   = hid_q + HID_W'(1);
          state_d = ST_U2_RD;
        end
      end
      ST_B_RD: state_d = ST_B_M1;
      ST_B_M1: state_d = ST_B_M2;
      ST_B_M2: state_d = ST_B_DH;
      ST_B_DH: state_d = ST_B_M3;
      ST_B_M3: state_d = ST_B_WR;
      ST_B_WR: begin
        if (hid_last) begin
          hid_d   = '0;
          inp_d   = '0;
          addr_d  = '0;
          state_d = ST_F_RD;
        end else begin
          hid_d   = hid_q + HID_W'(1);
          state_d = ST_B_RD;
        end
      end
      ST_F_RD: state_d = ST_F_M1;
      ST_F_M1: state_d = ST_F_M2;
      ST_F_M2: state_d = ST_F_WR;
      ST_F_WR: begin
        if (!inp_last) begin
          inp_d   = inp_q + INP_W'(1);
          addr_d  = addr_q + FA_W'(HIDDEN_COUNT);
          state_d = ST_F_RD;
        end else if (hid_last) begin
          state_d = ST_DONE;
        end else begin
          inp_d   = '0;
          hid_d   = hid_q + HID_W'(1);
          addr_d  = FA_W'(hid_q) + FA_W'(1);
          state_d = ST_F_RD;
        end
      end
      ST_DONE: if (!st_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.step = state_q;
    cmd_o.take = in_valid_i && (state_q == ST_IDLE);
    cmd_o.hid  = hid_q;
    cmd_o.inp  = inp_q;
    cmd_o.addr = addr_q;
  end

endmodule

### hdl/mbt_dp.sv
// Datapath: weight memories, shared multiplier, accumulator and result register.
module mbt_dp import mbt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mbt_cmd_t                 cmd_i,
  output mbt_status_t              st_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [WIDX_W-1:0]        weight_index_i,
  input  logic signed [WVAL_W-1:0] weight_value_i,
  input  logic [CELLS_W-1:0]       board_cells_i,
  input  logic [TGT_W-1:0]         target_position_i,
  input  logic [CFG_DATA_W-1:0]    momentum_factor_i,
  input  logic [CFG_DATA_W-1:0]    learning_rate_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ACT_W-1:0]         output_value_o,
  output logic [MOVE_W-1:0]        move_position_o,
  output logic [ACT_W-1:0]         squared_error_o
);

  typedef logic signed [WEIGHT_WIDTH-1:0] wgt_t;
  typedef logic signed [PROD_W-1:0]       wide_t;

  // Sigmoid table, built at elaboration.
  logic [ACT_W-1:0] sig_tab [SIG_SIZE];
  for (genvar e = 0; e < SIG_SIZE; e++) begin : g_sig
    localparam int N = (e >= SIG_SIZE / 2) ? 2 * e - (SIG_SIZE - 1) : (SIG_SIZE - 1) - 2 * e;
    localparam logic [63:0] P   = exp_pow(N);
    localparam logic [63:0] DEN = 64'h1_0000_0000 + P;
    localparam logic [63:0] NUM = (e >= SIG_SIZE / 2) ? 64'h1_0000_0000_0000 : (P << 16);
    localparam logic [63:0] VAL = (NUM + DEN / 2) / DEN;
    assign sig_tab[e] = VAL[ACT_W-1:0];
  end

  wgt_t             w1_mem [FIRST_COUNT];
  wgt_t             m1_mem [FIRST_COUNT];
  wgt_t             w2_mem [HIDDEN_COUNT];
  wgt_t             m2_mem [HIDDEN_COUNT];
  logic [ACT_W-1:0] ha_mem [HIDDEN_COUNT];
  wgt_t             hd_mem [HIDDEN_COUNT];

  wgt_t             w1_rd_q, m1_rd_q, w2_rd_q, m2_rd_q, hd_rd_q;
  logic [ACT_W-1:0] ha_rd_q;

  cmd_e                  cmd_q;
  logic [WIDX_W-1:0]     widx_q;
  logic signed [WVAL_W-1:0] wval_q;
  logic [ACT_W-1:0]      x_q [INPUT_COUNT];
  logic [TGT_W-1:0]      tgt_q;
  wide_t                 acc_q, prod_q;
  logic [ACT_W-1:0]      y_q, sq_q, dy_q;
  logic signed [MUL_B_W-1:0] err_q, yd_q;
  logic signed [MUL_A_W-1:0] e_q, t_q;
  logic                  out_valid_q;
  logic [ACT_W-1:0]      out_value_q, out_sq_q;
  logic [MOVE_W-1:0]     out_move_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  wide_t                     s_pre, s_off, g_upd, d_wide;
  wgt_t                      d_new, w_new, w_old;
  logic [SIG_IDX_W-1:0]      sig_idx;
  logic [ACT_W-1:0]          sig_val, x_sel;
  logic                      out_busy, out_load;
  logic [20:0]               y9;

  logic               w1_we, m1_we, w2_we, m2_we, ha_we, hd_we;
  logic [FA_W-1:0]    w1_wa;
  logic [HID_W-1:0]   w2_wa, m2_wa;
  wgt_t               w1_wd, m1_wd, w2_wd, m2_wd;

  assign x_sel    = x_q[cmd_i.inp];
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (cmd_i.step == ST_DONE) && !out_busy;
  assign st_o.cmd      = cmd_q;
  assign st_o.out_busy = out_busy;

  // Sigmoid lookup on the rounded accumulator; saturate outside [-8, 8).
  always_comb begin
    s_pre = round_sh(acc_q, 16);
    s_off = s_pre + SIG_HI;
    if (s_pre < SIG_LO) begin
      sig_idx = '0;
    end else if (s_pre >= SIG_HI) begin
      sig_idx = '1;
    end else begin
      sig_idx = s_off[SIG_IDX_LSB +: SIG_IDX_W];
    end
    sig_val = sig_tab[sig_idx];
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.step)
      ST_H_MUL: begin mul_a = MUL_A_W'(w1_rd_q); mul_b = {1'b0, x_sel}; end
      ST_O_MUL: begin mul_a = MUL_A_W'(w2_rd_q); mul_b = {1'b0, ha_rd_q}; end
      ST_E_SQ:  begin mul_a = MUL_A_W'(err_q); mul_b = err_q; end
      ST_E_DY:  begin mul_a = MUL_A_W'({1'b0, y_q}); mul_b = {1'b0, ONE_Q16 - y_q}; end
      ST_E_YD:  begin mul_a = -MUL_A_W'(err_q); mul_b = {1'b0, dy_q}; end
      ST_U2_M1: begin mul_a = MUL_A_W'(m2_rd_q); mul_b = MUL_B_W'({1'b0, momentum_factor_i}); end
      ST_U2_M2: begin mul_a = MUL_A_W'(yd_q); mul_b = {1'b0, ha_rd_q}; end
      ST_U2_M3: begin mul_a = prod_q[MUL_A_W-1:0]; mul_b = MUL_B_W'({1'b0, learning_rate_i}); end
      ST_B_M1:  begin mul_a = MUL_A_W'(w2_rd_q); mul_b = yd_q; end
      ST_B_M2:  begin mul_a = MUL_A_W'({1'b0, ha_rd_q}); mul_b = {1'b0, ONE_Q16 - ha_rd_q}; end
      ST_B_M3:  begin mul_a = e_q; mul_b = t_q[MUL_B_W-1:0]; end
      ST_F_M1:  begin mul_a = MUL_A_W'(m1_rd_q); mul_b = MUL_B_W'({1'b0, momentum_factor_i}); end
      ST_F_M2:  begin mul_a = MUL_A_W'(hd_rd_q); mul_b = MUL_B_W'({1'b0, learning_rate_i}); end
      default:  mul_en = 1'b0;
    endcase
  end

  // Momentum delta and new weight for both update passes.
  always_comb begin
    if (cmd_i.step == ST_U2_WR) begin
      g_upd = round_sh(prod_q, 32);
      w_old = w2_rd_q;
    end else begin
      w_old = w1_rd_q;
      if (x_sel == ONE_Q16) begin
        g_upd = round_sh(prod_q, 16);
      end else if (x_sel == '0) begin
        g_upd = '0;
      end else begin
        g_upd = round_sh(prod_q, 17);
      end
    end
    d_wide = PROD_W'(t_q) + g_upd;
    d_new  = sat_w(d_wide);
    w_new  = sat_w(PROD_W'(w_old) - PROD_W'(d_new));
  end

  // Memory write ports.
  always_comb begin
    w1_we = 1'b0; w1_wa = cmd_i.addr; w1_wd = w_new;
    m1_we = 1'b0; m1_wd = d_new;
    w2_we = 1'b0; w2_wa = cmd_i.hid; w2_wd = w_new;
    m2_we = 1'b0; m2_wa = cmd_i.hid; m2_wd = d_new;
    ha_we = (cmd_i.step == ST_H_SIG);
    hd_we = (cmd_i.step == ST_B_WR);
    unique case (cmd_i.step)
      ST_CLEAR: begin
        m1_we = 1'b1;
        m1_wd = '0;
        m2_we = (int'(cmd_i.addr) < HIDDEN_COUNT);
        m2_wa = cmd_i.addr[HID_W-1:0];
        m2_wd = '0;
      end
      ST_LOAD: begin
        if (int'(widx_q) < FIRST_COUNT) begin
          w1_we = 1'b1;
          w1_wa = widx_q[FA_W-1:0];
          w1_wd = sat_w(PROD_W'(wval_q));
        end else if (int'(widx_q) < WEIGHT_TOTAL) begin
          w2_we = 1'b1;
          w2_wa = HID_W'(int'(widx_q) - FIRST_COUNT);
          w2_wd = sat_w(PROD_W'(wval_q));
        end
      end
      ST_U2_WR: begin
        w2_we = 1'b1;
        m2_we = 1'b1;
      end
      ST_F_WR: begin
        w1_we = 1'b1;
        m1_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    w1_rd_q <= w1_mem[cmd_i.addr];
    if (w1_we) w1_mem[w1_wa] <= w1_wd;
  end

  always_ff @(posedge clk_i) begin
    m1_rd_q <= m1_mem[cmd_i.addr];
    if (m1_we) m1_mem[cmd_i.addr] <= m1_wd;
  end

  always_ff @(posedge clk_i) begin
    w2_rd_q <= w2_mem[cmd_i.hid];
    if (w2_we) w2_mem[w2_wa] <= w2_wd;
  end

  always_ff @(posedge clk_i) begin
    m2_rd_q <= m2_mem[cmd_i.hid];
    if (m2_we) m2_mem[m2_wa] <= m2_wd;
  end

  always_ff @(posedge clk_i) begin
    ha_rd_q <= ha_mem[cmd_i.hid];
    if (ha_we) ha_mem[cmd_i.hid] <= sig_val;
  end

  always_ff @(posedge clk_i) begin
    hd_rd_q <= hd_mem[cmd_i.hid];
    if (hd_we) hd_mem[cmd_i.hid] <= sat_w(round_sh(prod_q, 16));
  end

  // Capture the item, run the arithmetic steps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q  <= cmd_e'(command_i);
      widx_q <= weight_index_i;
      wval_q <= weight_value_i;
      tgt_q  <= target_position_i;
      acc_q  <= '0;
      for (int j = 0; j < INPUT_COUNT; j++) begin
        unique case (board_cells_i[2*j +: 2])
          2'd1:    x_q[j] <= ONE_Q16;
          2'd3:    x_q[j] <= '0;
          default: x_q[j] <= HALF_Q16;
        endcase
      end
    end
    if (mul_en) prod_q <= mul_a * mul_b;
    unique case (cmd_i.step)
      ST_H_ACC, ST_O_ACC: acc_q <= acc_q + prod_q;
      ST_H_SIG: acc_q <= '0;
      ST_O_SIG: begin
        acc_q <= '0;
        y_q   <= sig_val;
        err_q <= $signed({1'b0, desired_q16(tgt_q)}) - $signed({1'b0, sig_val});
      end
      ST_E_DY:  sq_q <= ACT_W'((prod_q + wide_t'(32768)) >>> 16);
      ST_E_DYR: dy_q <= ACT_W'(round_sh(prod_q, 16));
      ST_E_YDR: yd_q <= MUL_B_W'(round_sh(prod_q, 16));
      ST_U2_M2, ST_B_DH, ST_F_M2: t_q <= MUL_A_W'(round_sh(prod_q, 16));
      ST_B_M2:  e_q <= MUL_A_W'(round_sh(prod_q, 16));
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    y9 = ({4'b0, y_q} << 3) + {4'b0, y_q} + 21'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cmd_q == CMD_TRAIN || cmd_q == CMD_INFER) begin
        out_value_q <= y_q;
        out_move_q  <= y9[16 +: MOVE_W];
      end else begin
        out_value_q <= '0;
        out_move_q  <= '0;
      end
      out_sq_q <= (cmd_q == CMD_TRAIN) ? sq_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign output_value_o  = out_value_q;
  assign move_position_o = out_move_q;
  assign squared_error_o = out_sq_q;

endmodule
